[hw/rtl/lkv_pkg.sv]
package lkv_pkg;

   localparam int DEFAULT_ENTRIES = 16;

   localparam int KEY_W = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_CAPACITY_IDX = 1'b0;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } lkv_state_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_TOUCH,
      UPD_INSERT
   } lkv_op_type;

   typedef struct packed {
      lkv_op_type          op;
      logic                write_value;
      logic                evict;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } lkv_upd_type;

endpackage

[hw/rtl/lkv_if.sv]
interface lkv_req_if;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic signed [31:0]  key;
   logic signed [31:0]  value;

   modport source (output valid, output cmd, output key, output value, input ready);
   modport sink (input valid, input cmd, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
   logic                valid;
   logic                ready;
   logic                hit;
   logic signed [31:0]  read_value;
   logic                evicted;

   modport source (output valid, output hit, output read_value, output evicted, input ready);
   modport sink (input valid, input hit, input read_value, input evicted, output ready);
endinterface

[hw/rtl/lru_key_value_cache.sv]
// The idle state takes a transaction into the input registers; in the compare state
// the cells register their key match, and in the update state they update key, value
// and recency rank and the result is registered. Only the idle state takes a new one.
// A stalled result holds the update, and with it the input, until it is taken.
// Reset: synchronous, active high; clears all valid marks and ranks, the
// occupancy count and the result valid, and sets capacity to 16.
module lru_key_value_cache #(
   parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lkv_req_if.sink                              req_ch,
   lkv_rsp_if.source                            rsp_ch,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lkv_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [lkv_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [lkv_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import lkv_pkg::*;

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   lkv_state_type       state_ff, state_in;

   logic                cmd_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [VALUE_W-1:0]  value_ff;

   logic [CAP_W-1:0]    cap_ff;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                rsp_evicted_ff;

   logic                cell_match [ENTRIES];
   logic [RANK_W-1:0]   cell_rank [ENTRIES];
   logic [VALUE_W-1:0]  cell_value [ENTRIES];

   logic                hit_any;
   logic [RANK_W-1:0]   hit_rank;
   logic [VALUE_W-1:0]  hit_value;
   logic [RANK_W-1:0]   lru_rank;
   logic [CMP_W-1:0]    cap_eff;
   logic                evict;
   logic                out_load;
   logic                csr_write;
   lkv_upd_type         upd;

   // configuration
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[CSR_ADDR_W-1] == CSR_CAPACITY_IDX)
                      ? CSR_DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else if (csr_write && (paddr[CSR_ADDR_W-1] == CSR_CAPACITY_IDX)) begin
         cap_ff <= pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_eff > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end

   // cell row
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkv_cell #(
         .ENTRIES (ENTRIES),
         .INDEX   (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .lookup_key (key_ff),
         .upd        (upd),
         .hit_rank   (hit_rank),
         .lru_rank   (lru_rank),
         .count      (count_ff),
         .match      (cell_match[i]),
         .rank       (cell_rank[i]),
         .value      (cell_value[i])
      );
   end

   always_comb begin
      hit_any   = 1'b0;
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_any = hit_any | cell_match[i];
         if (cell_match[i]) begin
            hit_rank  = hit_rank | cell_rank[i];
            hit_value = hit_value | cell_value[i];
         end
      end
   end

   assign lru_rank = RANK_W'(count_ff - 1'b1);
   assign evict    = (cmd_ff == CMD_PUT) && !hit_any && (CMP_W'(count_ff) >= cap_eff);

   // control
   always_comb begin
      state_in         = state_ff;
      out_load         = 1'b0;
      upd.op           = UPD_NONE;
      upd.write_value  = (cmd_ff == CMD_PUT);
      upd.evict        = evict;
      upd.key          = key_ff;
      upd.value        = value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               if (hit_any) begin
                  upd.op = UPD_TOUCH;
               end else if (cmd_ff == CMD_PUT) begin
                  upd.op = UPD_INSERT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      count_in = count_ff;
      if (out_load && (cmd_ff == CMD_PUT) && !hit_any && !evict) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         cmd_ff   <= req_ch.cmd;
         key_ff   <= req_ch.key;
         value_ff <= req_ch.value;
      end
      if (out_load) begin
         rsp_hit_ff     <= hit_any;
         rsp_evicted_ff <= evict;
         if (cmd_ff == CMD_PUT) begin
            rsp_value_ff <= '0;
         end else if (hit_any) begin
            rsp_value_ff <= hit_value;
         end else begin
            rsp_value_ff <= MISS_VALUE;
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hit        = rsp_hit_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.evicted    = rsp_evicted_ff;

endmodule

[hw/rtl/lkv_cell.sv]
module lkv_cell #(
   parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES,
   parameter int INDEX = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [lkv_pkg::KEY_W-1:0]             lookup_key,
   input  lkv_pkg::lkv_upd_type                  upd,
   input  logic [$clog2(ENTRIES)-1:0]            hit_rank,
   input  logic [$clog2(ENTRIES)-1:0]            lru_rank,
   input  logic [$clog2(ENTRIES+1)-1:0]          count,
   output logic                                  match,
   output logic [$clog2(ENTRIES)-1:0]            rank,
   output logic [lkv_pkg::VALUE_W-1:0]           value
);
   import lkv_pkg::*;

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic                valid_ff, valid_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                match_ff, match_in;
   logic                victim;

   assign match_in = valid_ff && (key_ff == lookup_key);

   assign victim = upd.evict ? (valid_ff && (rank_ff == lru_rank))
                             : (CNT_W'(INDEX) == count);

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      case (upd.op)
         UPD_TOUCH: begin
            if (match_ff) begin
               rank_in = '0;
               if (upd.write_value) begin
                  value_in = upd.value;
               end
            end else if (valid_ff && (rank_ff < hit_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         UPD_INSERT: begin
            if (victim) begin
               valid_in = 1'b1;
               key_in   = upd.key;
               value_in = upd.value;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign match = match_ff;
   assign rank  = rank_ff;
   assign value = value_ff;

endmodule

[hw/rtl/lkv_checker.sv]
module lkv_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic         rsp_hit,
   input logic [31:0]  rsp_read_value,
   input logic         rsp_evicted
);
   import lkv_pkg::*;

   // one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted while previous one in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_read_value) && $stable(rsp_evicted))
      else $error("stalled response changed");

   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit)
      else $error("eviction reported on a hit");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_read_value == MISS_VALUE) || (rsp_read_value == '0))
      else $error("miss returned a stored value");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_hit        (rsp_ch.hit),
   .rsp_read_value (rsp_ch.read_value),
   .rsp_evicted    (rsp_ch.evicted)
);

[verif/lru_key_value_cache_tb.sv]
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
   import lkv_pkg::*;

   localparam int SLOTS = DEFAULT_ENTRIES;
   localparam int SPARE_REG_IDX = 1;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = CSR_ADDR_W'(4 * int'(CSR_CAPACITY_IDX));
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4 * SPARE_REG_IDX);
   localparam int PHASE_ITEMS = 102;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic                hit;
      logic [VALUE_W-1:0]  read_value;
      logic                evicted;
   } lookup_result_type;

   class lru_cache_scoreboard;
      bit                  slot_valid [SLOTS];
      logic [KEY_W-1:0]    slot_key [SLOTS];
      logic [VALUE_W-1:0]  slot_value [SLOTS];
      int unsigned         slot_rank [SLOTS];
      logic [CAP_W-1:0]    capacity;
      lookup_result_type   lookup_results_q [$];
      int unsigned         mismatches;
      int unsigned         printed;

      function new();
         for (int j = 0; j < SLOTS; j++) begin
            slot_valid[j] = 1'b0;
            slot_key[j] = '0;
            slot_value[j] = '0;
            slot_rank[j] = 0;
         end
         capacity = CAPACITY_RESET;
         mismatches = 0;
         printed = 0;
      endfunction

      function int pending();
         return lookup_results_q.size();
      endfunction

      // slot s becomes most recent; slots ahead of it slide back one place
      function void promote(int s);
         for (int j = 0; j < SLOTS; j++) begin
            if (slot_valid[j] && j != s && slot_rank[j] < slot_rank[s]) begin
               slot_rank[j]++;
            end
         end
         slot_rank[s] = 0;
      endfunction

      function void apply_command(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
         int                eff_cap;
         int                count;
         int                hit_slot;
         int                victim;
         int                free_slot;
         int unsigned       oldest;
         lookup_result_type res;
         eff_cap = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : int'(capacity);
         count = 0;
         hit_slot = -1;
         for (int j = 0; j < SLOTS; j++) begin
            if (slot_valid[j]) begin
               count++;
               if (hit_slot < 0 && slot_key[j] == key) begin
                  hit_slot = j;
               end
            end
         end
         res.hit = (hit_slot >= 0);
         res.read_value = '0;
         res.evicted = 1'b0;
         if (cmd == CMD_GET) begin
            if (res.hit) begin
               res.read_value = slot_value[hit_slot];
               promote(hit_slot);
            end else begin
               res.read_value = MISS_VALUE;
            end
         end else if (res.hit) begin
            slot_value[hit_slot] = value;
            promote(hit_slot);
         end else begin
            if (count >= eff_cap && count > 0) begin
               victim = -1;
               oldest = 0;
               for (int j = 0; j < SLOTS; j++) begin
                  if (slot_valid[j] && (victim < 0 || slot_rank[j] > oldest)) begin
                     victim = j;
                     oldest = slot_rank[j];
                  end
               end
               slot_valid[victim] = 1'b0;
               res.evicted = 1'b1;
            end
            free_slot = -1;
            for (int j = 0; j < SLOTS; j++) begin
               if (slot_valid[j]) begin
                  slot_rank[j]++;
               end else if (free_slot < 0) begin
                  free_slot = j;
               end
            end
            if (free_slot >= 0) begin
               slot_valid[free_slot] = 1'b1;
               slot_key[free_slot] = key;
               slot_value[free_slot] = value;
               slot_rank[free_slot] = 0;
            end
         end
         lookup_results_q.push_back(res);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (printed < MAX_PRINTED) begin
            printed++;
            $display("%0t mismatch: %s", $realtime, msg);
         end
      endtask

      task check_response(logic hit, logic [VALUE_W-1:0] read_value, logic evicted);
         lookup_result_type exp;
         if (lookup_results_q.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            exp = lookup_results_q.pop_front();
            if (hit !== exp.hit) begin
               report_mismatch($sformatf("hit %b, want %b", hit, exp.hit));
            end
            if (read_value !== exp.read_value) begin
               report_mismatch($sformatf("read_value %h, want %h", read_value,
                                         exp.read_value));
            end
            if (evicted !== exp.evicted) begin
               report_mismatch($sformatf("evicted %b, want %b", evicted, exp.evicted));
            end
         end
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   lkv_req_if req_ch ();
   lkv_rsp_if rsp_ch ();

   lru_key_value_cache i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   lru_cache_scoreboard sb = new();
   bit                  rsp_hold_req = 1'b0;
   int                  burst_left = 0;
   int                  stall_cycles = 0;
   logic [KEY_W-1:0]    key_pool [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.apply_command(req_ch.cmd, req_ch.key, req_ch.value);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_response(rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // response side: stretches of no, light and heavy backpressure, plus requested long holds
   initial begin
      int style;
      int stretch;
      rsp_ch.ready <= 1'b0;
      style = 0;
      stretch = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (stretch == 0) begin
               style = $urandom_range(2);
               stretch = $urandom_range(4, 80);
            end
            stretch--;
            case (style)
               0: begin
                  rsp_ch.ready <= 1'b1;
               end
               1: begin
                  rsp_ch.ready <= ($urandom_range(99) < 70);
               end
               default: begin
                  rsp_ch.ready <= ($urandom_range(99) < 25);
               end
            endcase
         end
      end
   end

   task send_item(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.key <= key;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // the first wait lets the scoreboard count the last accepted transaction
   task drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // upper data bits carry noise; only the low CAP_W bits land
   task set_capacity(logic [CAP_W-1:0] cap);
      logic [CSR_DATA_W-1:0] word;
      word = ($urandom() & ~CSR_DATA_W'(32'h1F)) | CSR_DATA_W'(cap);
      csr_write(CAPACITY_ADDR, word);
      sb.capacity = cap;
   endtask

   task build_key_pool(int eff_cap);
      int n;
      n = eff_cap + $urandom_range(0, 6);
      if (n < 2) begin
         n = 2;
      end
      key_pool.delete();
      for (int j = 0; j < n; j++) begin
         case ($urandom_range(19))
            0: key_pool.push_back(32'h8000_0000);
            1: key_pool.push_back(32'h7FFF_FFFF);
            2: key_pool.push_back(32'hFFFF_FFFF);
            3: key_pool.push_back(32'h0000_0000);
            default: key_pool.push_back($urandom());
         endcase
      end
   endtask

   task send_random();
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               cmd;
      if ($urandom_range(99) < 88) begin
         key = key_pool[$urandom_range(key_pool.size() - 1)];
      end else begin
         key = $urandom();
      end
      case ($urandom_range(15))
         0: value = 32'h8000_0000;
         1: value = 32'h7FFF_FFFF;
         2: value = 32'hFFFF_FFFF;
         default: value = $urandom();
      endcase
      cmd = $urandom_range(1) ? CMD_PUT : CMD_GET;
      send_item(cmd, key, value);
   endtask

   initial begin
      int caps [11];
      int eff_cap;

      caps = '{1, 16, 0, 4, 31, 2, 8, 17, 3, 12, 16};
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_GET;
      req_ch.key <= '0;
      req_ch.value <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset capacity, empty store
      send_item(CMD_GET, 32'h0000_0000, 32'h5A5A_5A5A);
      send_item(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_PUT, 32'h8000_0000, 32'h0000_0000);
      send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
      send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);

      // capacity dropped below occupancy
      drain();
      set_capacity(5'd2);
      send_item(CMD_PUT, 32'h0000_0001, 32'hAAAA_AAAA);
      send_item(CMD_PUT, 32'h0000_0000, 32'h5555_5555);
      send_item(CMD_PUT, 32'h0000_0002, 32'h0000_0001);
      send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);

      // zero capacity acts as one
      drain();
      set_capacity(5'd0);
      send_item(CMD_PUT, 32'h0000_0003, 32'h0000_0033);
      send_item(CMD_PUT, 32'h0000_0004, 32'h0000_0044);
      send_item(CMD_GET, 32'h0000_0003, 32'h0000_0000);
      send_item(CMD_GET, 32'h0000_0004, 32'h0000_0000);

      // write to unmapped register is dropped; oversized capacity saturates
      drain();
      csr_write(SPARE_ADDR, 32'h0000_0001);
      set_capacity(5'd31);
      send_item(CMD_PUT, 32'h0000_0005, 32'h0000_0055);
      send_item(CMD_PUT, 32'h0000_0006, 32'h0000_0066);
      send_item(CMD_PUT, 32'h0000_0007, 32'h0000_0077);
      send_item(CMD_GET, 32'h0000_0004, 32'h0000_0000);

      for (int p = 0; p < 11; p++) begin
         drain();
         if (p % 2 == 1) begin
            csr_write(SPARE_ADDR, $urandom());
         end
         set_capacity(CAP_W'(caps[p]));
         eff_cap = (caps[p] == 0) ? 1 : (caps[p] > SLOTS) ? SLOTS : caps[p];
         build_key_pool(eff_cap);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == 40 && (p == 2 || p == 7)) begin
               rsp_hold_req = 1'b1;
            end
            if (i == 60 && p % 3 == 0) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (sb.pending() != 0) @(posedge clock);
               @(posedge clock);
               burst_left = 0;
            end
            send_random();
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_if.sv
hw/rtl/lkv_cell.sv
hw/rtl/lru_key_value_cache.sv
hw/rtl/lkv_checker.sv
verif/lru_key_value_cache_tb.sv
